// ===== sv/triangle_face_normal_core_defines.svh =====
// Assertion macros shared by the face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TFN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfn check failed");

// Next-cycle implication, checked out of reset.
`define TFN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfn check failed");

`endif

// ===== sv/tfn_pkg.sv =====
package tfn_pkg;
    // Normalized magnitude width and result precision
    localparam int KEEP_BITS = 24;
    localparam int Q_BITS    = 15;
    localparam int OUT_W     = 16;
    localparam int SQ_W      = 2 * KEEP_BITS;
    localparam int S_W       = SQ_W + 2;
    localparam int RHS_SHIFT = 30;
    localparam int D_W       = 84;
    localparam int P_W       = 68;
    localparam int LANES     = 3;

    typedef logic [Q_BITS-1:0]       t_q;
    typedef logic signed [D_W-1:0]   t_dval;
    typedef logic signed [P_W-1:0]   t_pval;
    typedef logic [S_W-1:0]          t_sum;

    // Control that rides along the rounding pipeline
    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [LANES-1:0] neg;
    } t_ctl;
endpackage

// ===== sv/tfn_round_step.sv =====
// One bit of the rounded quotient search, for all three lanes.
module tfn_round_step
    import tfn_pkg::*;
#(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_q    i_q [LANES],
    input  t_dval i_d [LANES],
    input  t_pval i_p [LANES],
    input  t_sum  i_s [LANES],
    output t_ctl  o_ctl,
    output t_q    o_q [LANES],
    output t_dval o_d [LANES],
    output t_pval o_p [LANES],
    output t_sum  o_s [LANES]
);
    t_q    n_q [LANES];
    t_dval n_d [LANES];
    t_pval n_p [LANES];

    // Try setting bit K: cost of the step against the remaining slack
    always_comb begin
        t_dval term;
        logic  fit;
        for (int l = 0; l < LANES; l++) begin
            term = (D_W'(i_p[l]) <<< (K + 2)) + $signed(D_W'(i_s[l]) << (2 * K + 2));
            fit  = !i_q[l][Q_BITS-1] && (term <= i_d[l]);
            n_q[l] = fit ? (i_q[l] | (Q_BITS'(1) << K)) : i_q[l];
            n_d[l] = fit ? (i_d[l] - term) : i_d[l];
            n_p[l] = fit ? (i_p[l] + $signed(P_W'(i_s[l]) << (K + 1))) : i_p[l];
        end
    end

    // Advance the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.degen <= i_ctl.degen;
        o_ctl.neg   <= i_ctl.neg;
        o_q <= n_q;
        o_d <= n_d;
        o_p <= n_p;
        o_s <= i_s;
    end
endmodule

// ===== sv/triangle_face_normal_core.sv =====
// Triangle face normal: takes three Q7.8 vertices on a start strobe and, at the end
// of the pipeline, pulses o_valid for one cycle with the unit normal of (b-a)x(c-a)
// as Q1.14 components, rounded to nearest. A new triangle may start every cycle;
// busy is always low, and the receiver must take each word in its strobe cycle.
// The pipeline is the seven front stages (edges, products, cross, length,
// shift, squares, sum) plus one stage per bit of the fifteen-bit rounding search
// and the output register. A zero cross product gives a zero normal with
// o_degenerate set.
`include "triangle_face_normal_core_defines.svh"
module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by_coord,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    output logic                          o_valid,
    output logic signed [OUT_W-1:0]       o_nx,
    output logic signed [OUT_W-1:0]       o_ny,
    output logic signed [OUT_W-1:0]       o_nz,
    output logic                          o_degenerate
);
    localparam int EW_W  = COORD_WIDTH + 1;
    localparam int PR_W  = 2 * EW_W;
    localparam int CW    = PR_W + 1;
    localparam int XW    = (CW > KEEP_BITS) ? CW : KEEP_BITS;
    localparam int LW    = $clog2(CW + 1);
    localparam int LAT   = 8 + Q_BITS;

    assign busy = 1'b0;

    // Stage 1: edge vectors
    logic              r_v1;
    logic signed [EW_W-1:0] r_u [LANES];
    logic signed [EW_W-1:0] r_w [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_u[0] <= EW_W'(i_bx) - EW_W'(i_ax);
        r_u[1] <= EW_W'(i_by_coord) - EW_W'(i_ay);
        r_u[2] <= EW_W'(i_bz) - EW_W'(i_az);
        r_w[0] <= EW_W'(i_cx) - EW_W'(i_ax);
        r_w[1] <= EW_W'(i_cy) - EW_W'(i_ay);
        r_w[2] <= EW_W'(i_cz) - EW_W'(i_az);
    end

    // Stage 2: six partial products
    logic                   r_v2;
    logic signed [PR_W-1:0] r_pa [LANES];
    logic signed [PR_W-1:0] r_pb [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_pa[0] <= r_u[1] * r_w[2];
        r_pb[0] <= r_u[2] * r_w[1];
        r_pa[1] <= r_u[2] * r_w[0];
        r_pb[1] <= r_u[0] * r_w[2];
        r_pa[2] <= r_u[0] * r_w[1];
        r_pb[2] <= r_u[1] * r_w[0];
    end

    // Stage 3: cross components as sign and magnitude
    logic                  r_v3;
    logic [LANES-1:0]      r_neg3;
    logic [CW-1:0]         r_mag3 [LANES];

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] cr;
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int l = 0; l < LANES; l++) begin
            cr = CW'(r_pa[l]) - CW'(r_pb[l]);
            r_neg3[l] <= cr[CW-1];
            r_mag3[l] <= cr[CW-1] ? CW'(-cr) : CW'(cr);
        end
    end

    // Stage 4: bit length of the largest magnitude, shift amount
    logic             r_v4;
    logic             r_deg4;
    logic [LANES-1:0] r_neg4;
    logic [LW-1:0]    r_sh4;
    logic [CW-1:0]    r_mag4 [LANES];
    logic [CW-1:0]    any_bits;
    logic [LW-1:0]    len;

    always_comb begin
        any_bits = r_mag3[0] | r_mag3[1] | r_mag3[2];
        len = '0;
        for (int i = 0; i < CW; i++) begin
            if (any_bits[i]) begin
                len = LW'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_deg4 <= (any_bits == '0);
        r_neg4 <= r_neg3;
        r_sh4  <= (len > LW'(KEEP_BITS)) ? LW'(len - LW'(KEEP_BITS)) : '0;
        r_mag4 <= r_mag3;
    end

    // Stage 5: drop low bits to keep 24 significant bits
    logic                 r_v5;
    logic                 r_deg5;
    logic [LANES-1:0]     r_neg5;
    logic [KEEP_BITS-1:0] r_m5 [LANES];

    always_ff @(posedge i_clk) begin
        logic [XW-1:0] ext;
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_deg5 <= r_deg4;
        r_neg5 <= r_neg4;
        for (int l = 0; l < LANES; l++) begin
            ext = XW'(r_mag4[l]) >> r_sh4;
            r_m5[l] <= ext[KEEP_BITS-1:0];
        end
    end

    // Stage 6: squares
    logic             r_v6;
    logic             r_deg6;
    logic [LANES-1:0] r_neg6;
    logic [SQ_W-1:0]  r_sq6 [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_deg6 <= r_deg5;
        r_neg6 <= r_neg5;
        for (int l = 0; l < LANES; l++) begin
            r_sq6[l] <= SQ_W'(r_m5[l]) * SQ_W'(r_m5[l]);
        end
    end

    // Stage 7: sum of squares, seed the rounding search at q = 0
    t_ctl  r_ctl7;
    t_q    r_q7 [LANES];
    t_dval r_d7 [LANES];
    t_pval r_p7 [LANES];
    t_sum  r_s7 [LANES];
    t_sum  sum_sq;

    assign sum_sq = S_W'(r_sq6[0]) + S_W'(r_sq6[1]) + S_W'(r_sq6[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl7.valid <= 1'b0;
        end else begin
            r_ctl7.valid <= r_v6;
        end
        r_ctl7.degen <= r_deg6;
        r_ctl7.neg   <= r_neg6;
        for (int l = 0; l < LANES; l++) begin
            r_q7[l] <= '0;
            r_d7[l] <= $signed(D_W'(r_sq6[l]) << RHS_SHIFT) - $signed(D_W'(sum_sq));
            r_p7[l] <= -$signed(P_W'(sum_sq));
            r_s7[l] <= sum_sq;
        end
    end

    // Rounding search, one quotient bit per stage from the top
    t_ctl  st_ctl [Q_BITS+1];
    t_q    st_q   [Q_BITS+1][LANES];
    t_dval st_d   [Q_BITS+1][LANES];
    t_pval st_p   [Q_BITS+1][LANES];
    t_sum  st_s   [Q_BITS+1][LANES];

    assign st_ctl[0] = r_ctl7;
    assign st_q[0]   = r_q7;
    assign st_d[0]   = r_d7;
    assign st_p[0]   = r_p7;
    assign st_s[0]   = r_s7;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_step
        tfn_round_step #(
            .K(Q_BITS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (st_ctl[g]),
            .i_q     (st_q[g]),
            .i_d     (st_d[g]),
            .i_p     (st_p[g]),
            .i_s     (st_s[g]),
            .o_ctl   (st_ctl[g+1]),
            .o_q     (st_q[g+1]),
            .o_d     (st_d[g+1]),
            .o_p     (st_p[g+1]),
            .o_s     (st_s[g+1])
        );
    end

    // Output register: apply signs, zero a degenerate word
    t_ctl fin_ctl;
    logic signed [OUT_W-1:0] n_comp [LANES];

    assign fin_ctl = st_ctl[Q_BITS];

    always_comb begin
        logic signed [OUT_W-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            mag = $signed(OUT_W'(st_q[Q_BITS][l]));
            if (fin_ctl.degen) begin
                n_comp[l] = '0;
            end else begin
                n_comp[l] = fin_ctl.neg[l] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= fin_ctl.valid;
        end
        o_nx         <= n_comp[0];
        o_ny         <= n_comp[1];
        o_nz         <= n_comp[2];
        o_degenerate <= fin_ctl.degen;
    end

    `TFN_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_nx == '0 && o_ny == '0 && o_nz == '0)
    `TFN_ASSERT_NOW(a_live_nonzero, i_clk, i_rst_n, o_valid && !o_degenerate,
        o_nx != '0 || o_ny != '0 || o_nz != '0)
    `TFN_ASSERT_NOW(a_unit_range, i_clk, i_rst_n, o_valid,
        o_nx >= -16384 && o_nx <= 16384 && o_ny >= -16384 && o_ny <= 16384 &&
        o_nz >= -16384 && o_nz <= 16384)
    `TFN_ASSERT_NOW(a_latency, i_clk, i_rst_n, o_valid, $past(start, LAT))
endmodule
